// ===== sv/rhpm_pkg.sv =====
// Shared types and constants of the rolling hash pattern matcher.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rhpm_pkg;

    // Width of hash values, modulus and multiplier operands
    localparam int HW = 16;

    localparam logic [7:0]    CHAR_BASE   = 8'd97;
    localparam logic [8:0]    RADIX_RESET = 9'd256;
    localparam logic [HW-1:0] MOD_RESET   = 16'd65521;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_PAT   = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_RADIX   = 1'b0;
    localparam logic [0:0] REG_MODULUS = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } rhpm_item_t;

    typedef struct packed {
        logic        hash_hit;
        logic        match;
        logic [15:0] match_position;
        logic [15:0] match_count;
        logic [15:0] last_position;
        logic        found_any;
        logic        done_res;
    } rhpm_result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rhpm_mm_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RADIX,
        ST_CHAR,
        ST_WHASH,
        ST_OLD,
        ST_HPOW,
        ST_SUB,
        ST_ROLL,
        ST_PHASH,
        ST_PROLL,
        ST_HPMUL,
        ST_CMP,
        ST_FIN
    } rhpm_state_t;

endpackage

`default_nettype wire

// ===== sv/rolling_hash_pattern_matcher.sv =====
// Top level of the streaming Rabin-Karp matcher: sequencer, state and result register.
// Depends on rhpm_pkg and rhpm_mulmod.
`default_nettype none

// Streaming Rabin-Karp matcher. Send a clear word first, then pattern
// characters (last marks the final one), then text characters. Every word
// returns one result word. Every modular multiply runs through one shared
// bit-serial multiplier that works through a start step, one step per bit
// of b and a done step per operation. A clear word or an ignored pattern
// word needs no multiply; an accepted pattern character takes 4 multiplies
// plus 2 more when it is not the first; a text character takes up to 8
// multiplies plus a byte compare of the pattern after a hash hit. One word
// is worked on at a time; the result register lets the next word enter
// while a result still waits on result_stall. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while no
// word is in flight, which the block itself does not enforce. A modulus below 2 acts as 2.
module rolling_hash_pattern_matcher #(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65536
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire rhpm_pkg::rhpm_item_t  item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output rhpm_pkg::rhpm_result_t     result,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);
    import rhpm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TW = $clog2(TEXT_MAX);
    localparam int CW = ((TW + 1) > LW) ? (TW + 1) : LW;
    localparam int PW = (CW > 16) ? CW : 16;

    // Configuration
    logic [8:0]    radix_reg;
    logic [HW-1:0] modulus_reg;

    // Persistent matcher state
    logic [7:0]    pat_mem [PATTERN_MAX];
    logic [7:0]    win_reg [PATTERN_MAX];
    logic [LW-1:0] len_reg;
    logic [HW-1:0] phash_reg;
    logic [HW-1:0] whash_reg;
    logic [HW-1:0] hpow_reg;
    logic [TW-1:0] tidx_reg;
    logic [15:0]   count_reg;
    logic [15:0]   recent_reg;
    logic          found_reg;
    logic          locked_reg;

    // Per-word work registers
    rhpm_state_t   state_reg, state_next;
    rhpm_item_t    item_reg;
    logic          work_reg;
    logic [HW-1:0] r_reg;
    logic [HW-1:0] v_reg;
    logic [HW-1:0] wwork_reg;
    logic [HW-1:0] oldv_reg;
    logic [HW-1:0] hpred_reg;
    logic [HW-1:0] phred_reg;
    logic [7:0]    oldch_reg;
    logic [IW-1:0] j_reg;
    logic          hit_reg;
    logic          match_reg;

    rhpm_result_t  result_reg;
    logic          rvalid_reg;

    // Multiplier hookup
    rhpm_mm_stat_t mm_stat;
    logic [HW-1:0] mm_res;
    logic [HW-1:0] mm_a, mm_b;
    logic          op_state;
    logic          mm_start;
    logic          mm_done;

    logic [HW-1:0] q_eff;
    logic [7:0]    src_ch;
    logic          src_neg;
    logic [7:0]    src_diff;
    logic [HW-1:0] cval;
    logic          accept;
    logic          fin_go;
    logic [CW-1:0] cur_w, m_w;
    logic          have_pat;
    logic          full_win;
    logic          hit_now;
    logic [IW-1:0] m_last;
    logic [IW-1:0] cmp_idx;
    logic          cmp_eq;
    logic          cmp_end;
    logic [PW-1:0] mpos_w;
    logic [15:0]   mpos;
    logic [15:0]   count_next;
    logic [15:0]   recent_next;
    logic          found_next;

    function automatic logic [HW-1:0] add_mod(input logic [HW-1:0] x,
                                              input logic [HW-1:0] y,
                                              input logic [HW-1:0] q);
        logic [HW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q})
            s = s - {1'b0, q};
        return s[HW-1:0];
    endfunction

    assign q_eff    = (modulus_reg < HW'(2)) ? HW'(2) : modulus_reg;
    assign accept   = item_valid && !item_stall;
    assign fin_go   = (state_reg == ST_FIN) && (!rvalid_reg || !result_stall);
    assign mm_done  = mm_stat.done;
    assign mm_start = op_state && !mm_stat.busy && !mm_stat.done;

    // Character value: (code - 97) mod q, folded up from below when negative
    assign src_ch   = (state_reg == ST_OLD) ? oldch_reg : item_reg.ch;
    assign src_neg  = src_ch < CHAR_BASE;
    assign src_diff = src_neg ? (CHAR_BASE - src_ch) : (src_ch - CHAR_BASE);
    assign cval     = (src_neg && (mm_res != '0)) ? (q_eff - mm_res) : mm_res;

    // Window geometry
    assign cur_w    = CW'(tidx_reg);
    assign m_w      = CW'(len_reg);
    assign have_pat = (len_reg != '0);
    assign full_win = cur_w >= m_w;
    assign m_last   = IW'(len_reg - 1'b1);
    assign hit_now  = have_pat && ((cur_w + 1'b1) >= m_w) && (wwork_reg == mm_res);
    assign cmp_idx  = IW'(len_reg - 1'b1 - LW'(j_reg));
    assign cmp_eq   = pat_mem[j_reg] == win_reg[cmp_idx];
    assign cmp_end  = (LW'(j_reg) + 1'b1) == len_reg;
    assign mpos_w   = PW'(tidx_reg) + 1'b1 - PW'(len_reg);
    assign mpos     = match_reg ? mpos_w[15:0] : 16'd0;

    assign count_next  = (match_reg && (count_reg != 16'hFFFF)) ? count_reg + 1'b1
                                                                 : count_reg;
    assign recent_next = match_reg ? mpos : recent_reg;
    assign found_next  = found_reg || match_reg;

    rhpm_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .q     (q_eff),
        .stat  (mm_stat),
        .res   (mm_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (item.kind == KIND_TEXT)
                        state_next = ST_RADIX;
                    else if ((item.kind == KIND_PAT) && !locked_reg
                             && (len_reg < LW'(PATTERN_MAX)))
                        state_next = ST_RADIX;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_RADIX: if (mm_done) state_next = ST_CHAR;
            ST_CHAR:
            begin
                if (mm_done)
                    state_next = (item_reg.kind == KIND_TEXT) ? ST_WHASH : ST_PHASH;
            end
            ST_WHASH:
            begin
                if (mm_done)
                begin
                    priority if (have_pat && full_win)
                        state_next = ST_OLD;
                    else if (have_pat)
                        state_next = ST_ROLL;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_OLD:  if (mm_done) state_next = ST_HPOW;
            ST_HPOW:
            begin
                if (mm_done)
                    state_next = (item_reg.kind == KIND_TEXT) ? ST_SUB : ST_HPMUL;
            end
            ST_SUB:  if (mm_done) state_next = ST_ROLL;
            ST_ROLL: if (mm_done) state_next = ST_PHASH;
            ST_PHASH:
            begin
                if (mm_done)
                begin
                    priority if (item_reg.kind != KIND_TEXT)
                        state_next = ST_PROLL;
                    else if (hit_now)
                        state_next = ST_CMP;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_PROLL: if (mm_done) state_next = have_pat ? ST_HPOW : ST_FIN;
            ST_HPMUL: if (mm_done) state_next = ST_FIN;
            ST_CMP:   if (!cmp_eq || cmp_end) state_next = ST_FIN;
            ST_FIN:   if (fin_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Multiplier operands per state
    always_comb
    begin
        op_state = 1'b1;
        mm_a     = HW'(1);
        mm_b     = '0;
        unique case (state_reg)
            ST_RADIX: mm_b = HW'(radix_reg);
            ST_CHAR:  mm_b = HW'(src_diff);
            ST_OLD:   mm_b = HW'(src_diff);
            ST_WHASH: mm_b = whash_reg;
            ST_HPOW:  mm_b = hpow_reg;
            ST_PHASH: mm_b = phash_reg;
            ST_SUB:
            begin
                mm_a = oldv_reg;
                mm_b = hpred_reg;
            end
            ST_ROLL:
            begin
                mm_a = r_reg;
                mm_b = wwork_reg;
            end
            ST_PROLL:
            begin
                mm_a = r_reg;
                mm_b = phred_reg;
            end
            ST_HPMUL:
            begin
                mm_a = hpred_reg;
                mm_b = r_reg;
            end
            default:  op_state = 1'b0;
        endcase
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    // Control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rvalid_reg  <= 1'b0;
            radix_reg   <= RADIX_RESET;
            modulus_reg <= MOD_RESET;
            len_reg     <= '0;
            phash_reg   <= '0;
            whash_reg   <= '0;
            hpow_reg    <= HW'(1);
            tidx_reg    <= '0;
            count_reg   <= '0;
            recent_reg  <= '0;
            found_reg   <= 1'b0;
            locked_reg  <= 1'b0;
            for (int k = 0; k < PATTERN_MAX; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RADIX:   radix_reg   <= cfg_data[8:0];
                    REG_MODULUS: modulus_reg <= cfg_data;
                    default:     ;
                endcase
            end

            // Hold the result until taken, then drop valid
            if (fin_go)
                rvalid_reg <= 1'b1;
            else if (!result_stall)
                rvalid_reg <= 1'b0;

            // Shift the new text character in; the outgoing one is latched alongside
            if ((state_reg == ST_WHASH) && mm_done)
            begin
                for (int k = PATTERN_MAX - 1; k > 0; k--)
                    win_reg[k] <= win_reg[k-1];
                win_reg[0] <= item_reg.ch;
            end

            if ((state_reg == ST_PROLL) && mm_done)
            begin
                phash_reg <= add_mod(mm_res, v_reg, q_eff);
                if (!have_pat)
                    hpow_reg <= HW'(1);
            end

            if ((state_reg == ST_HPMUL) && mm_done)
                hpow_reg <= mm_res;

            if (fin_go)
            begin
                unique case (item_reg.kind)
                    KIND_CLEAR:
                    begin
                        len_reg    <= '0;
                        phash_reg  <= '0;
                        hpow_reg   <= HW'(1);
                        count_reg  <= '0;
                        recent_reg <= '0;
                        found_reg  <= 1'b0;
                        locked_reg <= 1'b0;
                        whash_reg  <= '0;
                        tidx_reg   <= '0;
                        for (int k = 0; k < PATTERN_MAX; k++)
                            win_reg[k] <= '0;
                    end
                    KIND_PAT:
                    begin
                        if (work_reg)
                            len_reg <= len_reg + 1'b1;
                        if (item_reg.last)
                            locked_reg <= 1'b1;
                    end
                    KIND_TEXT:
                    begin
                        locked_reg <= 1'b1;
                        count_reg  <= count_next;
                        recent_reg <= recent_next;
                        found_reg  <= found_next;
                        if (item_reg.last)
                        begin
                            // End of text: restart the window, keep the tallies
                            whash_reg <= '0;
                            tidx_reg  <= '0;
                            for (int k = 0; k < PATTERN_MAX; k++)
                                win_reg[k] <= '0;
                        end
                        else
                        begin
                            whash_reg <= wwork_reg;
                            if (tidx_reg != TW'(TEXT_MAX - 1))
                                tidx_reg <= tidx_reg + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Per-word datapath, pattern memory and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg  <= item;
            work_reg  <= !locked_reg && (len_reg < LW'(PATTERN_MAX));
            hit_reg   <= 1'b0;
            match_reg <= 1'b0;
        end

        if (mm_done)
        begin
            unique case (state_reg)
                ST_RADIX: r_reg <= mm_res;
                ST_CHAR:  v_reg <= cval;
                ST_OLD:   oldv_reg <= cval;
                ST_HPOW:  hpred_reg <= mm_res;
                ST_WHASH:
                begin
                    wwork_reg <= mm_res;
                    oldch_reg <= win_reg[m_last];
                end
                ST_SUB:   wwork_reg <= add_mod(wwork_reg, q_eff - mm_res, q_eff);
                ST_ROLL:  wwork_reg <= add_mod(mm_res, v_reg, q_eff);
                ST_PHASH:
                begin
                    phred_reg <= mm_res;
                    j_reg     <= '0;
                    if ((item_reg.kind == KIND_TEXT) && hit_now)
                        hit_reg <= 1'b1;
                end
                default: ;
            endcase
        end

        // Byte compare, one pattern position per cycle
        if (state_reg == ST_CMP)
        begin
            j_reg <= j_reg + 1'b1;
            if (cmp_eq && cmp_end)
                match_reg <= 1'b1;
        end

        if (fin_go && (item_reg.kind == KIND_PAT) && work_reg)
            pat_mem[IW'(len_reg)] <= item_reg.ch;

        if (fin_go)
        begin
            if (item_reg.kind == KIND_CLEAR)
            begin
                result_reg.hash_hit       <= 1'b0;
                result_reg.match          <= 1'b0;
                result_reg.match_position <= '0;
                result_reg.match_count    <= '0;
                result_reg.last_position  <= '0;
                result_reg.found_any      <= 1'b0;
            end
            else if (item_reg.kind == KIND_TEXT)
            begin
                result_reg.hash_hit       <= hit_reg;
                result_reg.match          <= match_reg;
                result_reg.match_position <= mpos;
                result_reg.match_count    <= count_next;
                result_reg.last_position  <= recent_next;
                result_reg.found_any      <= found_next;
            end
            else
            begin
                result_reg.hash_hit       <= 1'b0;
                result_reg.match          <= 1'b0;
                result_reg.match_position <= '0;
                result_reg.match_count    <= count_reg;
                result_reg.last_position  <= recent_reg;
                result_reg.found_any      <= found_reg;
            end
            result_reg.done_res <= item_reg.last;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rhpm_mulmod.sv =====
// Bit-serial modular multiplier: res = (a * b) mod q, one bit of b per cycle.
// Depends on rhpm_pkg. Operand a must already lie below q.
`default_nettype none

module rhpm_mulmod (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [rhpm_pkg::HW-1:0] a,
    input  wire logic [rhpm_pkg::HW-1:0] b,
    input  wire logic [rhpm_pkg::HW-1:0] q,
    output rhpm_pkg::rhpm_mm_stat_t     stat,
    output logic [rhpm_pkg::HW-1:0]     res
);
    import rhpm_pkg::*;

    localparam int CNTW = $clog2(HW);

    logic [HW-1:0]   acc_reg, acc_next;
    logic [HW-1:0]   a_reg;
    logic [HW-1:0]   b_reg;
    logic [HW-1:0]   q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [HW+1:0]   s0, s1, s2;

    // Horner step: double, add a on a set bit, fold back below q twice
    always_comb
    begin
        s0 = {1'b0, acc_reg, 1'b0} + (b_reg[HW-1] ? {2'b00, a_reg} : '0);
        s1 = (s0 >= {2'b00, q_reg}) ? s0 - {2'b00, q_reg} : s0;
        s2 = (s1 >= {2'b00, q_reg}) ? s1 - {2'b00, q_reg} : s1;
        acc_next = s2[HW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(HW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            q_reg   <= q;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[HW-2:0], 1'b0};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = acc_reg;

endmodule

`default_nettype wire

// ===== sv/rhpm_checker.sv =====
// Port-level checks of the matcher and the bind that attaches them.
// Depends on rhpm_pkg and rolling_hash_pattern_matcher.
`default_nettype none

module rhpm_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire logic                  item_stall,
    input  wire rhpm_pkg::rhpm_item_t  item,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire rhpm_pkg::rhpm_result_t result,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [15:0]           cfg_data
);
    import rhpm_pkg::*;

    // A waiting result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // One word at a time: an accepted word blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after accepting a word");

    // A verified match always comes with a hash hit
    a_match_has_hit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.match || result.hash_hit))
        else $error("match without hash hit");

    // The found flag tracks a nonzero count
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.found_any == (result.match_count != 16'd0)))
        else $error("found_any disagrees with match_count");

endmodule

bind rolling_hash_pattern_matcher rhpm_checker u_rhpm_checker (.*);

`default_nettype wire

// ===== bench/rolling_hash_pattern_matcher_test.sv =====
// Testbench of the rolling hash pattern matcher: directed and random words, with a checker.
// Depends on rhpm_pkg and the rolling_hash_pattern_matcher top level.
`default_nettype none

module rolling_hash_pattern_matcher_test;
    import rhpm_pkg::*;

    localparam int PMAX      = 16;
    localparam int TMAX      = 65536;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE    = 400;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    rhpm_item_t   item = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    rhpm_result_t result;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = REG_RADIX;
    logic [15:0]  cfg_data = '0;

    rolling_hash_pattern_matcher DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state of the matcher
    logic [8:0]  mr_radix;
    logic [15:0] mr_modulus;
    logic [7:0]  pat_bytes [PMAX];
    int unsigned pat_len;
    logic [7:0]  win_bytes [PMAX];
    int unsigned pat_hash, win_hash, high_pow, text_pos, hits_seen, recent_pos;
    bit          any_hit, pat_locked;

    rhpm_item_t   pending_words [$];
    rhpm_result_t expected_results [$];
    int  fail_count = 0;
    int  words_sent = 0, results_seen = 0, matches_total = 0;
    bit  hold_sender = 1'b0;
    bit  long_stall_req = 1'b0;
    bit  timed_out = 1'b0;

    function automatic int unsigned char_value(logic [7:0] c, int unsigned q);
        if (c >= CHAR_BASE)
            return (c - CHAR_BASE) % q;
        return (q - ((CHAR_BASE - c) % q)) % q;
    endfunction

    function automatic int unsigned mulmod(int unsigned a, int unsigned b, int unsigned q);
        longint unsigned p;
        p = longint'(a) * longint'(b);
        return int'(p % q);
    endfunction

    task automatic clear_window();
        for (int k = 0; k < PMAX; k++)
            win_bytes[k] = '0;
        win_hash = 0;
        text_pos = 0;
    endtask

    task automatic clear_matcher();
        for (int k = 0; k < PMAX; k++)
            pat_bytes[k] = '0;
        pat_len = 0;
        pat_hash = 0;
        high_pow = 1;
        hits_seen = 0;
        recent_pos = 0;
        any_hit = 0;
        pat_locked = 0;
        clear_window();
    endtask

    // Work out the result of one accepted word and advance the predictor
    task automatic predict_word(rhpm_item_t w);
        rhpm_result_t r;
        int unsigned q, rd, v, m, cur, wh, sub;
        bit same;
        q = (mr_modulus < 2) ? 2 : mr_modulus;
        rd = mr_radix % q;
        r = '0;
        case (w.kind)
            KIND_CLEAR: clear_matcher();
            KIND_PAT:
            begin
                if (!pat_locked && pat_len < PMAX) begin
                    v = char_value(w.ch, q);
                    pat_bytes[pat_len] = w.ch;
                    pat_hash = (mulmod(rd, pat_hash % q, q) + v) % q;
                    high_pow = (pat_len > 0) ? mulmod(high_pow % q, rd, q) : 1;
                    pat_len++;
                end
                if (w.last)
                    pat_locked = 1;
            end
            KIND_TEXT:
            begin
                m = pat_len;
                v = char_value(w.ch, q);
                cur = text_pos;
                wh = win_hash % q;
                pat_locked = 1;
                if (m > 0) begin
                    if (cur >= m) begin
                        sub = mulmod(char_value(win_bytes[m-1], q), high_pow % q, q);
                        wh = (wh + q - sub) % q;
                    end
                    wh = (mulmod(rd, wh, q) + v) % q;
                end
                win_hash = wh;
                for (int k = PMAX - 1; k > 0; k--)
                    win_bytes[k] = win_bytes[k-1];
                win_bytes[0] = w.ch;
                if (m > 0 && cur + 1 >= m && wh == pat_hash % q) begin
                    r.hash_hit = 1'b1;
                    same = 1;
                    for (int j = 0; j < m; j++)
                        if (pat_bytes[j] != win_bytes[m-1-j])
                            same = 0;
                    if (same) begin
                        r.match = 1'b1;
                        r.match_position = 16'(cur + 1 - m);
                        if (hits_seen < 16'hFFFF)
                            hits_seen++;
                        recent_pos = r.match_position;
                        any_hit = 1;
                    end
                end
                if (text_pos < TMAX - 1)
                    text_pos++;
                if (w.last)
                    clear_window();
            end
            default: ;
        endcase
        r.match_count   = 16'(hits_seen);
        r.last_position = 16'(recent_pos);
        r.found_any     = any_hit;
        r.done_res      = w.last;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH result %0d %s: got %0h expected %0h", results_seen, what, got, want);
        fail_count++;
    endtask

    // Driver: bursts of words with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                predict_word(item);
                words_sent++;
            end
            if (item_valid && item_stall) begin
                // hold the stalled word
            end else if (hold_sender || pending_words.size() == 0) begin
                item_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                item_valid <= 1'b0;
            end else begin
                item <= pending_words.pop_front();
                item_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest expectation
    int stall_phase = 0;
    int long_left = 0;
    always @(posedge clk) begin
        rhpm_result_t want;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (result.hash_hit !== want.hash_hit)
                        report_mismatch("hash_hit", result.hash_hit, want.hash_hit);
                    if (result.match !== want.match)
                        report_mismatch("match", result.match, want.match);
                    if (result.match_position !== want.match_position)
                        report_mismatch("match_position", result.match_position,
                                        want.match_position);
                    if (result.match_count !== want.match_count)
                        report_mismatch("match_count", result.match_count, want.match_count);
                    if (result.last_position !== want.last_position)
                        report_mismatch("last_position", result.last_position,
                                        want.last_position);
                    if (result.found_any !== want.found_any)
                        report_mismatch("found_any", result.found_any, want.found_any);
                    if (result.done_res !== want.done_res)
                        report_mismatch("done_res", result.done_res, want.done_res);
                    if (want.match)
                        matches_total++;
                end
                results_seen++;
            end
            // long hold-off on request, otherwise a stall pattern that drifts in phases
            if (long_stall_req && long_left == 0) begin
                long_left <= 3000;
                result_stall <= 1'b1;
            end else if (long_left > 1) begin
                long_left <= long_left - 1;
                result_stall <= 1'b1;
            end else begin
                if (long_left == 1)
                    long_left <= 0;
                stall_phase <= stall_phase + 1;
                if ((stall_phase / 500) % 3 == 0)
                    result_stall <= 1'b0;
                else
                    result_stall <= ($urandom_range(0, 99) < 40);
            end
        end
    end

    // Watchdog: count cycles in which no word moves
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic rhpm_item_t mk(logic [1:0] k, logic [7:0] c, logic l);
        rhpm_item_t w;
        w.kind = k;
        w.ch = c;
        w.last = l;
        return w;
    endfunction

    // Queue a clear word and a pattern, then text that embeds it at random places
    task automatic queue_session(int plen, int tlen, bit broken);
        logic [7:0] pat [PMAX];
        int alpha;
        alpha = $urandom_range(0, 3) == 0 ? 256 : $urandom_range(2, 4);
        pending_words.push_back(mk(KIND_CLEAR, 8'($urandom), 1'($urandom)));
        for (int i = 0; i < plen; i++) begin
            pat[i] = (alpha == 256) ? 8'($urandom) : 8'(CHAR_BASE + $urandom_range(0, alpha-1));
            pending_words.push_back(mk(KIND_PAT, pat[i], i == plen - 1));
        end
        if (broken)
            pending_words.push_back(mk(KIND_PAT, 8'($urandom), 1'($urandom)));
        for (int t = 0; t < tlen; t++) begin
            if ($urandom_range(0, 4) == 0 && t + plen < tlen) begin
                for (int i = 0; i < plen; i++)
                    pending_words.push_back(mk(KIND_TEXT, pat[i], 1'b0));
                t += plen - 1;
            end else begin
                pending_words.push_back(mk(KIND_TEXT,
                    (alpha == 256) ? 8'($urandom) : 8'(CHAR_BASE + $urandom_range(0, alpha-1)),
                    t == tlen - 1 || $urandom_range(0, 60) == 0));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || item_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        if (idx == REG_RADIX)
            mr_radix = 9'(val);
        else
            mr_modulus = 16'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int radix_set [6] = '{256, 1, 26, 2, 31, 256};
        int mod_set   [6] = '{65521, 65535, 2, 0, 101, 7};
        mr_radix = RADIX_RESET;
        mr_modulus = MOD_RESET;
        clear_matcher();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every kind, full and locked pattern, empty pattern
        pending_words.push_back(mk(KIND_TEXT, 8'hFF, 1'b0));
        pending_words.push_back(mk(KIND_TEXT, 8'h00, 1'b1));
        pending_words.push_back(mk(KIND_PAT, "a", 1'b0));
        pending_words.push_back(mk(KIND_PAT, "b", 1'b1));
        pending_words.push_back(mk(KIND_PAT, "c", 1'b0));
        pending_words.push_back(mk(KIND_UNUSED, 8'hFF, 1'b1));
        pending_words.push_back(mk(KIND_TEXT, "a", 1'b0));
        pending_words.push_back(mk(KIND_TEXT, "b", 1'b0));
        pending_words.push_back(mk(KIND_TEXT, "a", 1'b0));
        pending_words.push_back(mk(KIND_TEXT, "b", 1'b1));
        pending_words.push_back(mk(KIND_CLEAR, 8'hFF, 1'b1));
        for (int i = 0; i < 17; i++)
            pending_words.push_back(mk(KIND_PAT, 8'(i * 15), 1'b0));
        pending_words.push_back(mk(KIND_CLEAR, 8'h00, 1'b0));
        wait_drained();

        // Random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_RADIX, radix_set[ph]);
            write_reg(REG_MODULUS, mod_set[ph]);
            if (ph == 1) begin
                // hold off the receiver while words keep coming
                queue_session(3, 40, 0);
                long_stall_req = 1'b1;
                wait (long_left != 0);
                long_stall_req = 1'b0;
            end
            while (pending_words.size() < 280) begin
                if ($urandom_range(0, 9) == 0)
                    pending_words.push_back(mk(2'($urandom), 8'($urandom), 1'($urandom)));
                else
                    queue_session(($urandom_range(0, 9) == 0) ? PMAX : $urandom_range(1, 5),
                                  $urandom_range(10, 60), $urandom_range(0, 7) == 0);
            end
            if (ph == 3) begin
                // pause the sender until every result is back
                while (pending_words.size() > 150)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (item_valid || expected_results.size() != 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        $display("Covered %0d words and %0d results with %0d verified matches",
                 words_sent, results_seen, matches_total);
        $display("over six radix and modulus settings, including modulus 0, 2 and 65535.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire

// ===== rolling_hash_pattern_matcher.f =====
sv/rhpm_pkg.sv
sv/rhpm_mulmod.sv
sv/rolling_hash_pattern_matcher.sv
sv/rhpm_checker.sv
bench/rolling_hash_pattern_matcher_test.sv
